FILE: rtl/core/pixel_to_ansi_text_encoder_unit_macros.svh
// Assertion macros shared by the checker of the pixel to ANSI text encoder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PIXEL_TO_ANSI_TEXT_ENCODER_UNIT_MACROS_SVH
`define PIXEL_TO_ANSI_TEXT_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define P2A_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define P2A_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/p2a_pkg.sv
// Package of the pixel to ANSI text encoder: payload types, command format,
// sequencer states and character codes. It depends on nothing.
`default_nettype none

package p2a_pkg;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TABLE = 1'b1;

    localparam logic [1:0] MODE_GRAY  = 2'd0;
    localparam logic [1:0] MODE_COLOR = 2'd1;
    localparam logic [1:0] MODE_HALF  = 2'd2;
    localparam logic [1:0] MODE_FIXED = 2'd3;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIXED = 8'd1;
    localparam logic [6:0] FIXED_CHAR_RESET = 7'd35;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_AW + 1;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_FG     = 8'h33;
    localparam logic [7:0] CH_BG     = 8'h34;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_UTF0   = 8'hE2;
    localparam logic [7:0] CH_UTF1   = 8'h96;
    localparam logic [7:0] CH_UTF2   = 8'h80;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] red_low;
        logic [7:0] green_low;
        logic [7:0] blue_low;
        logic       row_end;
        logic [7:0] table_index;
        logic [6:0] table_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] fixed_char;
    } cfg_t;

    typedef struct packed {
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } dec_t;

    typedef struct packed {
        logic [1:0]      mode;
        logic            row_end;
        logic [6:0]      glyph;
        dec_t [2:0]      fg;
        dec_t [2:0]      bg;
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ESC,
        ST_LBRACK,
        ST_LAYER,
        ST_EIGHT,
        ST_SEMI_A,
        ST_TWO,
        ST_SEMI_B,
        ST_HUND,
        ST_TENS,
        ST_ONES,
        ST_SEP,
        ST_GLYPH,
        ST_UTF0,
        ST_UTF1,
        ST_UTF2,
        ST_RST_ESC,
        ST_RST_LB,
        ST_RST_ZERO,
        ST_RST_M,
        ST_NEWLINE
    } seq_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/pixel_to_ansi_text_encoder_unit.sv
// Top level of the pixel to ANSI text encoder: configuration registers and
// the front end, command queue and byte sequencer. Depends on p2a_pkg.
//
// Input items arrive on in_valid/in_stall with an in_item_t payload. A pixel
// item produces its terminal text as one byte per beat on out_valid/out_stall,
// and last_byte marks the final byte of that item. A table write item fills
// one entry of the 256-entry character table and produces no beat.
// Registers are written on the cfg port (index 0 display mode, 1 fixed
// character); the user must write them only while the block is idle, which
// the block itself does not enforce. cfg_ready is always high. The sequencer
// sends one byte per cycle while the receiver does not stall. A pixel has
// one or two bytes in gray mode, up to 25 in colored and fixed-character
// modes and up to 46 in half-block mode. Pixels are accepted back to back as
// long as the commands in the eight-entry queue plus the items in the four
// front stages number fewer than eight; in_stall rises when they reach eight.
// When the receiver stalls, the output beat holds and the queue absorbs new
// pixels until it fills. Reset empties all stages, selects gray mode and sets
// the fixed character to '#'; the character table is not cleared.
`default_nettype none

module pixel_to_ansi_text_encoder_unit (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  p2a_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  wire                               out_stall,
    output p2a_pkg::out_item_t                out_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [p2a_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [p2a_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import p2a_pkg::*;

    cfg_t                   cfg_reg, cfg_next;
    logic                   push_valid;
    cmd_t                   push_data;
    logic                   pop;
    logic                   head_valid;
    cmd_t                   head_data;
    logic [QUEUE_CNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_MODE:  cfg_next.mode = cfg_data[1:0];
                CFG_IDX_FIXED: cfg_next.fixed_char = cfg_data[6:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_GRAY;
            cfg_reg.fixed_char <= FIXED_CHAR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    p2a_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg        (cfg_reg),
        .q_count    (q_count),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    p2a_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (q_count)
    );

    p2a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/p2a_front.sv
// Front end of the pixel to ANSI text encoder: accepts items, computes luma,
// owns the character table and pushes byte commands. Depends on p2a_pkg.
`default_nettype none

module p2a_front (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  p2a_pkg::in_item_t                 in_data,
    input  p2a_pkg::cfg_t                     cfg,
    input  wire [p2a_pkg::QUEUE_CNT_W-1:0]    q_count,
    output logic                              push_valid,
    output p2a_pkg::cmd_t                     push_data
);
    import p2a_pkg::*;

    localparam int SUM_W    = 18;
    localparam int PROD_W   = 29;
    localparam int CREDIT_W = QUEUE_CNT_W + 1;

    typedef struct packed {
        logic       row_end;
        dec_t [2:0] fg;
        dec_t [2:0] bg;
    } pix_t;

    function automatic dec_t to_dec(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        dec_t        d;
        if (v >= 8'd200)
        begin
            h = 2'd2;
            r = 7'(v - 8'd200);
        end
        else if (v >= 8'd100)
        begin
            h = 2'd1;
            r = 7'(v - 8'd100);
        end
        else
        begin
            h = 2'd0;
            r = v[6:0];
        end
        p = {8'b0, r} * 15'd205;
        t = 4'(p >> 11);
        d.hund = h;
        d.tens = t;
        d.ones = 4'(r - 7'({3'b0, t} * 7'd10));
        return d;
    endfunction

    logic             s1_valid_reg, s1_valid_next;
    in_item_t         s1_item_reg;
    logic [SUM_W-1:0] s1_sum_reg, s1_sum_next;

    logic             s2_valid_reg, s2_valid_next;
    pix_t             s2_pix_reg, s2_pix_next;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [7:0]       s2_qest_reg, s2_qest_next;
    logic [PROD_W-1:0] qest_prod;
    logic             s2_wr_reg, s2_wr_next;
    logic [7:0]       s2_wr_index_reg;
    logic [6:0]       s2_wr_char_reg;

    logic             s3_valid_reg;
    pix_t             s3_pix_reg;
    logic [7:0]       s3_luma_reg, s3_luma_next;
    logic [SUM_W-1:0] rem_val;
    logic             s3_wr_reg;
    logic [7:0]       s3_wr_index_reg;
    logic [6:0]       s3_wr_char_reg;

    logic             s4_valid_reg;
    pix_t             s4_pix_reg;
    logic [6:0]       table_rd_reg;

    logic [6:0]       char_table [256];
    logic [2:0]       inflight;
    logic [CREDIT_W-1:0] credit_used;

    assign inflight = 3'(s1_valid_reg) + 3'(s2_valid_reg) + 3'(s3_valid_reg)
                    + 3'(s4_valid_reg);
    assign credit_used = {1'b0, q_count} + CREDIT_W'(inflight);
    assign in_stall = credit_used >= CREDIT_W'(QUEUE_DEPTH);

    always_comb
    begin
        s1_valid_next = in_valid && !in_stall;
        s1_sum_next = SUM_W'(18'd299 * {10'b0, in_data.red})
                    + SUM_W'(18'd587 * {10'b0, in_data.green})
                    + SUM_W'(18'd114 * {10'b0, in_data.blue});
    end

    always_comb
    begin
        s2_valid_next = s1_valid_reg && (s1_item_reg.kind == KIND_PIXEL);
        s2_wr_next = s1_valid_reg && (s1_item_reg.kind == KIND_TABLE);
        qest_prod = {11'b0, s1_sum_reg} * 29'd1048;
        s2_qest_next = 8'(qest_prod >> 20);
        s2_pix_next.row_end = s1_item_reg.row_end;
        s2_pix_next.fg[0] = to_dec(s1_item_reg.red);
        s2_pix_next.fg[1] = to_dec(s1_item_reg.green);
        s2_pix_next.fg[2] = to_dec(s1_item_reg.blue);
        s2_pix_next.bg[0] = to_dec(s1_item_reg.red_low);
        s2_pix_next.bg[1] = to_dec(s1_item_reg.green_low);
        s2_pix_next.bg[2] = to_dec(s1_item_reg.blue_low);
    end

    always_comb
    begin
        rem_val = s2_sum_reg - SUM_W'({10'b0, s2_qest_reg} * 18'd1000);
        s3_luma_next = s2_qest_reg + 8'(rem_val >= 18'd1000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s2_wr_reg    <= 1'b0;
            s3_wr_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s2_wr_reg    <= s2_wr_next;
            s3_wr_reg    <= s2_wr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg     <= in_data;
        s1_sum_reg      <= s1_sum_next;
        s2_pix_reg      <= s2_pix_next;
        s2_sum_reg      <= s1_sum_reg;
        s2_qest_reg     <= s2_qest_next;
        s2_wr_index_reg <= s1_item_reg.table_index;
        s2_wr_char_reg  <= s1_item_reg.table_char;
        s3_pix_reg      <= s2_pix_reg;
        s3_luma_reg     <= s3_luma_next;
        s3_wr_index_reg <= s2_wr_index_reg;
        s3_wr_char_reg  <= s2_wr_char_reg;
        s4_pix_reg      <= s3_pix_reg;
    end

    // Table writes land at the same stage where pixels read, so every pixel
    // sees exactly the writes that were accepted before it.
    always_ff @(posedge clk)
    begin
        if (s3_wr_reg)
        begin
            char_table[s3_wr_index_reg] <= s3_wr_char_reg;
        end
        table_rd_reg <= char_table[s3_luma_reg];
    end

    always_comb
    begin
        push_valid = s4_valid_reg;
        push_data.mode = cfg.mode;
        push_data.row_end = s4_pix_reg.row_end;
        push_data.glyph = (cfg.mode == MODE_FIXED) ? cfg.fixed_char : table_rd_reg;
        push_data.fg = s4_pix_reg.fg;
        push_data.bg = s4_pix_reg.bg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/p2a_queue.sv
// Command queue between the front end and the byte sequencer of the pixel
// to ANSI text encoder. Depends on p2a_pkg.
`default_nettype none

module p2a_queue (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             push_valid,
    input  p2a_pkg::cmd_t                   push_data,
    input  wire                             pop,
    output logic                            head_valid,
    output p2a_pkg::cmd_t                   head_data,
    output logic [p2a_pkg::QUEUE_CNT_W-1:0] count
);
    import p2a_pkg::*;

    cmd_t                   entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg + QUEUE_CNT_W'(push_valid) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = entries[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

FILE: rtl/core/p2a_back.sv
// Byte sequencer of the pixel to ANSI text encoder: expands one command into
// escape, digit and glyph bytes behind an output register. Depends on p2a_pkg.
`default_nettype none

module p2a_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 head_valid,
    input  p2a_pkg::cmd_t       head_data,
    output logic                pop,
    output logic                out_valid,
    input  wire                 out_stall,
    output p2a_pkg::out_item_t  out_data
);
    import p2a_pkg::*;

    seq_state_t state_reg, state_next;
    cmd_t       cmd_reg;
    logic       layer_reg, layer_next;
    logic [1:0] comp_reg, comp_next;
    logic       out_valid_reg;
    out_item_t  out_data_reg;

    logic       adv;
    logic       finish;
    dec_t       cur_dec;
    dec_t       nxt_dec;
    logic [7:0] byte_val;
    logic       last_val;

    function automatic dec_t sel_dec(input cmd_t c, input logic bg, input logic [1:0] idx);
        dec_t d;
        case (idx)
            2'd0: d = bg ? c.bg[0] : c.fg[0];
            2'd1: d = bg ? c.bg[1] : c.fg[1];
            2'd2: d = bg ? c.bg[2] : c.fg[2];
            default: d = bg ? c.bg[2] : c.fg[2];
        endcase
        return d;
    endfunction

    function automatic seq_state_t digit_start(input dec_t d);
        seq_state_t s;
        if (d.hund != 2'd0)
            s = ST_HUND;
        else if (d.tens != 4'd0)
            s = ST_TENS;
        else
            s = ST_ONES;
        return s;
    endfunction

    assign adv = (state_reg != ST_IDLE) && (!out_valid_reg || !out_stall);
    assign cur_dec = sel_dec(cmd_reg, layer_reg, comp_reg);
    assign nxt_dec = sel_dec(cmd_reg, layer_reg, comp_reg + 2'd1);

    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        comp_next = comp_reg;
        finish = 1'b0;
        pop = 1'b0;
        case (state_reg)
            ST_IDLE:     finish = 1'b1;
            ST_ESC:      state_next = ST_LBRACK;
            ST_LBRACK:   state_next = ST_LAYER;
            ST_LAYER:    state_next = ST_EIGHT;
            ST_EIGHT:    state_next = ST_SEMI_A;
            ST_SEMI_A:   state_next = ST_TWO;
            ST_TWO:      state_next = ST_SEMI_B;
            ST_SEMI_B:   state_next = digit_start(cur_dec);
            ST_HUND:     state_next = ST_TENS;
            ST_TENS:     state_next = ST_ONES;
            ST_ONES:     state_next = ST_SEP;
            ST_SEP:
            begin
                if (comp_reg != 2'd2)
                begin
                    comp_next = comp_reg + 2'd1;
                    state_next = digit_start(nxt_dec);
                end
                else if (!layer_reg && (cmd_reg.mode == MODE_HALF))
                begin
                    layer_next = 1'b1;
                    comp_next = 2'd0;
                    state_next = ST_ESC;
                end
                else if (cmd_reg.mode == MODE_HALF)
                    state_next = ST_UTF0;
                else
                    state_next = ST_GLYPH;
            end
            ST_GLYPH:
            begin
                if (cmd_reg.mode != MODE_GRAY)
                    state_next = ST_RST_ESC;
                else if (cmd_reg.row_end)
                    state_next = ST_NEWLINE;
                else
                    finish = 1'b1;
            end
            ST_UTF0:     state_next = ST_UTF1;
            ST_UTF1:     state_next = ST_UTF2;
            ST_UTF2:     state_next = ST_RST_ESC;
            ST_RST_ESC:  state_next = ST_RST_LB;
            ST_RST_LB:   state_next = ST_RST_ZERO;
            ST_RST_ZERO: state_next = ST_RST_M;
            ST_RST_M:
            begin
                if (cmd_reg.row_end)
                    state_next = ST_NEWLINE;
                else
                    finish = 1'b1;
            end
            ST_NEWLINE:  finish = 1'b1;
            default:     finish = 1'b1;
        endcase
        if (!adv && (state_reg != ST_IDLE))
        begin
            state_next = state_reg;
            layer_next = layer_reg;
            comp_next = comp_reg;
            finish = 1'b0;
        end
        if (finish)
        begin
            layer_next = 1'b0;
            comp_next = 2'd0;
            if (head_valid)
            begin
                pop = 1'b1;
                state_next = (head_data.mode == MODE_GRAY) ? ST_GLYPH : ST_ESC;
            end
            else
                state_next = ST_IDLE;
        end
    end

    always_comb
    begin
        byte_val = CH_ESC;
        last_val = 1'b0;
        case (state_reg)
            ST_IDLE:     byte_val = CH_ESC;
            ST_ESC:      byte_val = CH_ESC;
            ST_LBRACK:   byte_val = CH_LBRACK;
            ST_LAYER:    byte_val = layer_reg ? CH_BG : CH_FG;
            ST_EIGHT:    byte_val = CH_EIGHT;
            ST_SEMI_A:   byte_val = CH_SEMI;
            ST_TWO:      byte_val = CH_TWO;
            ST_SEMI_B:   byte_val = CH_SEMI;
            ST_HUND:     byte_val = CH_ZERO + {6'b0, cur_dec.hund};
            ST_TENS:     byte_val = CH_ZERO + {4'b0, cur_dec.tens};
            ST_ONES:     byte_val = CH_ZERO + {4'b0, cur_dec.ones};
            ST_SEP:      byte_val = (comp_reg == 2'd2) ? CH_M : CH_SEMI;
            ST_GLYPH:
            begin
                byte_val = {1'b0, cmd_reg.glyph};
                last_val = (cmd_reg.mode == MODE_GRAY) && !cmd_reg.row_end;
            end
            ST_UTF0:     byte_val = CH_UTF0;
            ST_UTF1:     byte_val = CH_UTF1;
            ST_UTF2:     byte_val = CH_UTF2;
            ST_RST_ESC:  byte_val = CH_ESC;
            ST_RST_LB:   byte_val = CH_LBRACK;
            ST_RST_ZERO: byte_val = CH_ZERO;
            ST_RST_M:
            begin
                byte_val = CH_M;
                last_val = !cmd_reg.row_end;
            end
            ST_NEWLINE:
            begin
                byte_val = CH_NL;
                last_val = 1'b1;
            end
            default:     byte_val = CH_ESC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            layer_reg     <= 1'b0;
            comp_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            comp_reg  <= comp_next;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head_data;
        if (adv)
        begin
            out_data_reg.out_byte  <= byte_val;
            out_data_reg.last_byte <= last_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/p2a_checker.sv
// Port-level checker for the pixel to ANSI text encoder and its bind.
// Depends on p2a_pkg and pixel_to_ansi_text_encoder_unit_macros.svh.
`default_nettype none
`include "pixel_to_ansi_text_encoder_unit_macros.svh"

module p2a_checker (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    input  wire                               in_stall,
    input  p2a_pkg::in_item_t                 in_data,
    input  wire                               out_valid,
    input  wire                               out_stall,
    input  p2a_pkg::out_item_t                out_data
);
    import p2a_pkg::*;

    logic       pix_in;
    logic       last_out;
    logic [4:0] pend_reg, pend_next;

    // Pixels accepted whose final byte has not yet been delivered.
    assign pix_in   = in_valid && !in_stall && (in_data.kind == KIND_PIXEL);
    assign last_out = out_valid && !out_stall && out_data.last_byte;

    always_comb
    begin
        pend_next = pend_reg + 5'(pix_in) - 5'(last_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    `P2A_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "output beat dropped while stalled")
    `P2A_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled output beat changed")
    `P2A_ASSERT_IMP(a_last_has_item, last_out, pend_reg != 5'd0, "final byte without a pending pixel")
    `P2A_ASSERT_IMP(a_idle_quiet, pend_reg == 5'd0, !out_valid, "output beat with no pending pixel")

endmodule

bind pixel_to_ansi_text_encoder_unit p2a_checker u_p2a_checker (.*);

`default_nettype wire
